[sv/slx_pkg.sv]
// Shared types, character codes, token kinds and helper functions for the lexer.
// Used by every lexer module.
package slx_pkg;

  localparam int POSITION_BITS = 32;
  localparam int LINE_BITS     = 24;
  localparam int COL_BITS      = 16;
  localparam int GRP_TOKENS    = 3;
  localparam int QUEUE_DEPTH   = 4;
  localparam int QUEUE_AW      = $clog2(QUEUE_DEPTH);

  // token kinds
  localparam logic [5:0] K_EOF    = 6'd0;
  localparam logic [5:0] K_BAD    = 6'd1;
  localparam logic [5:0] K_OPEN   = 6'd2;
  localparam logic [5:0] K_IDENT  = 6'd3;
  localparam logic [5:0] K_NUMBER = 6'd4;
  localparam logic [5:0] K_STRING = 6'd5;
  localparam logic [5:0] K_COMMA  = 6'd6;
  localparam logic [5:0] K_COLON  = 6'd7;
  localparam logic [5:0] K_LPAREN = 6'd8;
  localparam logic [5:0] K_RPAREN = 6'd9;
  localparam logic [5:0] K_LBRACE = 6'd10;
  localparam logic [5:0] K_RBRACE = 6'd11;
  localparam logic [5:0] K_PLUS   = 6'd12;
  localparam logic [5:0] K_MINUS  = 6'd13;
  localparam logic [5:0] K_ARROW  = 6'd14;
  localparam logic [5:0] K_STAR   = 6'd15;
  localparam logic [5:0] K_SLASH  = 6'd16;
  localparam logic [5:0] K_LT     = 6'd17;
  localparam logic [5:0] K_LE     = 6'd18;
  localparam logic [5:0] K_GT     = 6'd19;
  localparam logic [5:0] K_GE     = 6'd20;
  localparam logic [5:0] K_ASSIGN = 6'd21;
  localparam logic [5:0] K_EQ     = 6'd22;
  localparam logic [5:0] K_NOT    = 6'd23;
  localparam logic [5:0] K_NE     = 6'd24;
  localparam logic [5:0] K_AND    = 6'd25;
  localparam logic [5:0] K_OR     = 6'd26;

  // characters
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_AMP    = 8'h26;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_BAR    = 8'h7C;
  localparam logic [7:0] CH_RBRACE = 8'h7D;

  // keywords, first byte in the top byte, zero padded to six bytes
  localparam int KW_COUNT = 10;
  localparam logic [47:0] KW_TEXT [KW_COUNT] = '{
    {"else", 16'h0}, {"false", 8'h0}, {"fn", 32'h0}, {"for", 24'h0},
    {"if", 32'h0}, {"let", 24'h0}, {"print", 8'h0}, {"return"},
    {"true", 16'h0}, {"while", 8'h0}
  };
  localparam logic [5:0] KW_KIND [KW_COUNT] = '{
    6'd27, 6'd28, 6'd29, 6'd30, 6'd31, 6'd32, 6'd33, 6'd34, 6'd35, 6'd36
  };

  typedef enum logic [6:0] {
    PH_IDLE    = 7'b0000001,
    PH_IDENT   = 7'b0000010,
    PH_NUM     = 7'b0000100,
    PH_NUM_DOT = 7'b0001000,
    PH_FRAC    = 7'b0010000,
    PH_STR     = 7'b0100000,
    PH_OP      = 7'b1000000
  } phase_t;

  typedef struct packed {
    logic [POSITION_BITS-1:0] off;
    logic [LINE_BITS-1:0]     line;
    logic [COL_BITS-1:0]      col;
  } pos_t;

  typedef struct packed {
    logic [5:0]  kind;
    logic [31:0] offset;
    logic [31:0] length;
    logic [23:0] line;
    logic [15:0] column;
  } tok_t;

  // all tokens caused by one input word
  typedef struct packed {
    tok_t [GRP_TOKENS-1:0] tok;
    logic [1:0]            cnt;
  } grp_t;

  // what a byte does when it starts a token
  typedef struct packed {
    logic       ws;
    logic       emit;
    logic [5:0] kind;
    phase_t     phase;
  } cls_t;

  function automatic logic alpha_ch(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == CH_UNDER;
  endfunction

  function automatic logic digit_ch(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  // saturating position step
  function automatic pos_t adv(pos_t p, logic [7:0] c);
    pos_t r;
    r = p;
    if (p.off != '1) r.off = p.off + 1'b1;
    if (c == CH_LF) begin
      if (p.line != '1) r.line = p.line + 1'b1;
      r.col = COL_BITS'(1);
    end else if (p.col != '1) begin
      r.col = p.col + 1'b1;
    end
    return r;
  endfunction

  function automatic tok_t mk_tok(logic [5:0] k, pos_t s, pos_t c);
    tok_t t;
    logic [63:0] o64, l64, ln64;
    o64  = 64'(s.off);
    l64  = 64'(c.off - s.off);
    ln64 = 64'(s.line);
    t.kind   = k;
    t.offset = o64[31:0];
    t.length = l64[31:0];
    t.line   = ln64[23:0];
    t.column = s.col;
    return t;
  endfunction

  function automatic logic [5:0] kw_kind(logic [47:0] pre, logic [POSITION_BITS-1:0] len);
    logic [5:0] k;
    k = K_IDENT;
    if (len <= POSITION_BITS'(6)) begin
      for (int i = 0; i < KW_COUNT; i++) begin
        if (pre == KW_TEXT[i]) k = KW_KIND[i];
      end
    end
    return k;
  endfunction

  function automatic logic [5:0] single_kind(logic [7:0] c);
    case (c)
      CH_MINUS: return K_MINUS;
      CH_LT:    return K_LT;
      CH_GT:    return K_GT;
      CH_EQ:    return K_ASSIGN;
      CH_BANG:  return K_NOT;
      default:  return K_BAD;
    endcase
  endfunction

  // zero when the pair is not an operator
  function automatic logic [5:0] pair_kind(logic [7:0] c, logic [7:0] n);
    if (c == CH_MINUS && n == CH_GT) return K_ARROW;
    if (c == CH_LT && n == CH_EQ) return K_LE;
    if (c == CH_GT && n == CH_EQ) return K_GE;
    if (c == CH_EQ && n == CH_EQ) return K_EQ;
    if (c == CH_BANG && n == CH_EQ) return K_NE;
    if (c == CH_AMP && n == CH_AMP) return K_AND;
    if (c == CH_BAR && n == CH_BAR) return K_OR;
    return K_EOF;
  endfunction

  function automatic cls_t classify(logic [7:0] b);
    cls_t r;
    r.ws    = 1'b0;
    r.emit  = 1'b0;
    r.kind  = K_BAD;
    r.phase = PH_IDLE;
    if (b == CH_SPACE || b == CH_TAB || b == CH_LF || b == CH_CR) begin
      r.ws = 1'b1;
    end else if (alpha_ch(b)) begin
      r.phase = PH_IDENT;
    end else if (digit_ch(b)) begin
      r.phase = PH_NUM;
    end else begin
      r.emit = 1'b1;
      case (b)
        CH_QUOTE: begin r.emit = 1'b0; r.phase = PH_STR; end
        CH_COMMA:  r.kind = K_COMMA;
        CH_COLON:  r.kind = K_COLON;
        CH_LPAREN: r.kind = K_LPAREN;
        CH_RPAREN: r.kind = K_RPAREN;
        CH_LBRACE: r.kind = K_LBRACE;
        CH_RBRACE: r.kind = K_RBRACE;
        CH_PLUS:   r.kind = K_PLUS;
        CH_STAR:   r.kind = K_STAR;
        CH_SLASH:  r.kind = K_SLASH;
        CH_MINUS, CH_LT, CH_GT, CH_EQ, CH_BANG, CH_AMP, CH_BAR: begin
          r.emit  = 1'b0;
          r.phase = PH_OP;
        end
        default:   r.kind = K_BAD;
      endcase
    end
    return r;
  endfunction

endpackage

[sv/slx_ifs.sv]
// Valid/ready channel interfaces for source bytes and tokens.
interface slx_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] source_byte;
  logic       end_of_input;
  modport source(output valid, source_byte, end_of_input, input ready);
  modport sink(input valid, source_byte, end_of_input, output ready);
endinterface

interface slx_out_if;
  logic        valid;
  logic        ready;
  logic [5:0]  token_kind;
  logic [31:0] start_offset;
  logic [31:0] lexeme_len;
  logic [23:0] first_line;
  logic [15:0] first_col;
  logic        last_of_run;
  modport source(output valid, token_kind, start_offset, lexeme_len, first_line,
                 first_col, last_of_run, input ready);
  modport sink(input valid, token_kind, start_offset, lexeme_len, first_line,
               first_col, last_of_run, output ready);
endinterface

[sv/slx_front.sv]
// Front end: scanner state machine, takes one byte per cycle while the queue is
// not full and builds the group of tokens the byte completes. Depends on slx_pkg and slx_in_if.
module slx_front (
  input  logic              clk,
  input  logic              rst_n,
  slx_in_if.sink            in_chan,
  input  logic              q_full,
  output logic              push,
  output slx_pkg::grp_t     push_grp
);
  import slx_pkg::*;

  phase_t      ph_r, ph_nxt;
  pos_t        cur_r, cur_nxt;
  pos_t        st_r, st_nxt;
  logic [47:0] pre_r, pre_nxt;

  tok_t [GRP_TOKENS-1:0] toks;
  logic [1:0]  n;
  logic        is_end, do_flush, do_dot, do_start, en;
  logic [7:0]  b, sb;
  cls_t        cl;
  logic [5:0]  pk;
  logic [POSITION_BITS-1:0] len;
  logic        fire;

  assign b            = in_chan.source_byte;
  assign is_end       = in_chan.end_of_input || (b == 8'h00);
  assign in_chan.ready = !q_full;
  assign fire         = in_chan.valid && !q_full;

  // one byte of lexing: flush, optional dot restart, start on the byte, eof
  always_comb begin
    ph_nxt   = ph_r;
    cur_nxt  = cur_r;
    st_nxt   = st_r;
    pre_nxt  = pre_r;
    toks     = '0;
    n        = 2'd0;
    do_flush = 1'b0;
    do_dot   = 1'b0;
    do_start = 1'b0;
    len      = cur_r.off - st_r.off;
    pk       = pair_kind(pre_r[47:40], b);
    sb       = CH_DOT;
    en       = 1'b0;
    cl       = classify(b);

    if (is_end) begin
      do_flush = 1'b1;
    end else begin
      case (ph_r)
        PH_IDENT: begin
          if (alpha_ch(b) || digit_ch(b)) begin
            for (int k = 0; k < 6; k++) begin
              if (len == POSITION_BITS'(k)) pre_nxt[47-8*k -: 8] = b;
            end
            cur_nxt = adv(cur_r, b);
          end else begin
            do_flush = 1'b1; do_start = 1'b1;
          end
        end
        PH_NUM: begin
          if (digit_ch(b)) cur_nxt = adv(cur_r, b);
          else if (b == CH_DOT) ph_nxt = PH_NUM_DOT;
          else begin do_flush = 1'b1; do_start = 1'b1; end
        end
        PH_NUM_DOT: begin
          if (digit_ch(b)) begin
            cur_nxt = adv(adv(cur_r, CH_DOT), b);
            ph_nxt  = PH_FRAC;
          end else begin
            do_flush = 1'b1; do_start = 1'b1;
          end
        end
        PH_FRAC: begin
          if (digit_ch(b)) cur_nxt = adv(cur_r, b);
          else begin do_flush = 1'b1; do_start = 1'b1; end
        end
        PH_STR: begin
          cur_nxt = adv(cur_r, b);
          if (b == CH_QUOTE) begin
            toks[n] = mk_tok(K_STRING, st_r, cur_nxt); n = n + 2'd1;
            ph_nxt  = PH_IDLE;
          end
        end
        PH_OP: begin
          if (pk != K_EOF) begin
            cur_nxt = adv(cur_r, b);
            toks[n] = mk_tok(pk, st_r, cur_nxt); n = n + 2'd1;
            ph_nxt  = PH_IDLE;
          end else begin
            do_flush = 1'b1; do_start = 1'b1;
          end
        end
        default: do_start = 1'b1;
      endcase
    end

    // close the held token
    if (do_flush) begin
      case (ph_r)
        PH_IDENT: begin toks[n] = mk_tok(kw_kind(pre_r, len), st_r, cur_r); n = n + 2'd1; end
        PH_NUM, PH_FRAC: begin toks[n] = mk_tok(K_NUMBER, st_r, cur_r); n = n + 2'd1; end
        PH_NUM_DOT: begin
          toks[n] = mk_tok(K_NUMBER, st_r, cur_r); n = n + 2'd1;
          do_dot  = 1'b1;
        end
        PH_STR: begin toks[n] = mk_tok(K_OPEN, st_r, cur_r); n = n + 2'd1; end
        PH_OP: begin
          toks[n] = mk_tok(single_kind(pre_r[47:40]), st_r, cur_r); n = n + 2'd1;
        end
        default: ;
      endcase
      ph_nxt = PH_IDLE;
    end

    // start a token on the held dot, then on the byte
    for (int i = 0; i < 2; i++) begin
      sb = (i == 0) ? CH_DOT : b;
      en = (i == 0) ? do_dot : do_start;
      if (en) begin
        cl      = classify(sb);
        st_nxt  = cur_nxt;
        cur_nxt = adv(cur_nxt, sb);
        if (!cl.ws) begin
          ph_nxt = cl.phase;
          if (cl.phase == PH_IDENT) pre_nxt = {sb, 40'h0};
          if (cl.phase == PH_OP) pre_nxt[47:40] = sb;
          if (cl.emit) begin
            toks[n] = mk_tok(cl.kind, st_nxt, cur_nxt); n = n + 2'd1;
          end
        end
      end
    end

    if (is_end) begin
      st_nxt  = cur_nxt;
      toks[n] = mk_tok(K_EOF, st_nxt, cur_nxt); n = n + 2'd1;
    end
  end

  assign push         = fire && (n != 2'd0);
  assign push_grp.tok = toks;
  assign push_grp.cnt = n;

  // scanner state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r  <= PH_IDLE;
      cur_r <= '{off: '0, line: LINE_BITS'(1), col: COL_BITS'(1)};
      st_r  <= '{off: '0, line: LINE_BITS'(1), col: COL_BITS'(1)};
      pre_r <= '0;
    end else if (fire) begin
      ph_r  <= ph_nxt;
      cur_r <= cur_nxt;
      st_r  <= st_nxt;
      pre_r <= pre_nxt;
    end
  end

endmodule

[sv/slx_queue.sv]
// Short queue of token groups between the scanner and the output stage.
// Depends on slx_pkg.
module slx_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  slx_pkg::grp_t wr_grp,
  input  logic          pop,
  output slx_pkg::grp_t rd_grp,
  output logic          full,
  output logic          empty
);
  import slx_pkg::*;

  grp_t                mem_r [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wp_r, rp_r;
  logic [QUEUE_AW:0]   cnt_r;

  assign full   = cnt_r == (QUEUE_AW+1)'(QUEUE_DEPTH);
  assign empty  = cnt_r == '0;
  assign rd_grp = mem_r[rp_r];

  // storage
  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= wr_grp;
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop)  rp_r <= rp_r + 1'b1;
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

[sv/slx_back.sv]
// Back end: holds one token group and hands its tokens out one word at a time.
// Depends on slx_pkg and slx_out_if.
module slx_back (
  input  logic          clk,
  input  logic          rst_n,
  input  slx_pkg::grp_t rd_grp,
  input  logic          q_empty,
  output logic          pop,
  slx_out_if.source     out_chan
);
  import slx_pkg::*;

  grp_t       cur_r;
  logic [1:0] idx_r;
  logic       vld_r;
  logic       fire, last;
  tok_t       t;

  assign t    = cur_r.tok[idx_r];
  assign last = idx_r == (cur_r.cnt - 2'd1);
  assign fire = vld_r && out_chan.ready;
  assign pop  = (!vld_r || (fire && last)) && !q_empty;

  assign out_chan.valid        = vld_r;
  assign out_chan.token_kind   = t.kind;
  assign out_chan.start_offset = t.offset;
  assign out_chan.lexeme_len   = t.length;
  assign out_chan.first_line   = t.line;
  assign out_chan.first_col    = t.column;
  assign out_chan.last_of_run  = last;

  // group register payload
  always_ff @(posedge clk) begin
    if (pop) cur_r <= rd_grp;
  end

  // token index and valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
      idx_r <= 2'd0;
    end else if (pop) begin
      vld_r <= 1'b1;
      idx_r <= 2'd0;
    end else if (fire) begin
      if (last) vld_r <= 1'b0;
      else idx_r <= idx_r + 2'd1;
    end
  end

endmodule

[sv/script_token_lexer.sv]
// Token lexer top level: scanner front end, group queue, output back end.
// Takes one byte per cycle while the queue has room; each byte yields zero to three tokens.
// A token passes through the queue and then the group register before it appears.
// Output sends tokens one per cycle while the sink is ready.
// Reset (rst_n, synchronous, active low): scanner idle, position at offset 0 line 1 column 1,
// queue and output empty.
module script_token_lexer (
  input  logic      clk,
  input  logic      rst_n,
  slx_in_if.sink    in_chan,
  slx_out_if.source out_chan
);
  import slx_pkg::*;

  grp_t wr_grp, rd_grp;
  logic push, pop, q_full, q_empty;

  slx_front u_front (
    .clk(clk), .rst_n(rst_n), .in_chan(in_chan),
    .q_full(q_full), .push(push), .push_grp(wr_grp)
  );

  slx_queue u_queue (
    .clk(clk), .rst_n(rst_n), .push(push), .wr_grp(wr_grp),
    .pop(pop), .rd_grp(rd_grp), .full(q_full), .empty(q_empty)
  );

  slx_back u_back (
    .clk(clk), .rst_n(rst_n), .rd_grp(rd_grp), .q_empty(q_empty),
    .pop(pop), .out_chan(out_chan)
  );

endmodule

[test/script_token_lexer_test.sv]
// Self-checking testbench for the script token lexer: drives source bytes and
// compares every emitted token with an in-bench lexer model.
// Depends on slx_pkg, slx_ifs and script_token_lexer.
module script_token_lexer_test;
  import slx_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_IDENT, S_NUM, S_NUM_DOT, S_FRAC, S_STR, S_OP
  } scan_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       fin;
  } src_word_t;

  typedef struct packed {
    logic [5:0]  kind;
    logic [31:0] offset;
    logic [31:0] length;
    logic [23:0] line;
    logic [15:0] column;
    logic        last;
  } token_word_t;

  logic clk;
  logic rst_n;

  slx_in_if  in_chan ();
  slx_out_if out_chan ();

  script_token_lexer dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .out_chan(out_chan)
  );

  src_word_t   pending_bytes[$];
  token_word_t expected_tokens[$];
  int          mismatch_count;
  bit          stim_done;
  int          sent_count;
  bit          in_taken;

  // lexer model state
  scan_t       lx_phase;
  logic [31:0] lx_off, lx_tok_off;
  logic [23:0] lx_line, lx_tok_line;
  logic [15:0] lx_col, lx_tok_col;
  logic [7:0]  lx_prefix[6];
  token_word_t lx_run[$];

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #50_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic bit alpha_c(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction

  function automatic bit digit_c(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic void lx_clear();
    lx_phase = S_IDLE;
    lx_off = '0; lx_line = 24'd1; lx_col = 16'd1;
    lx_tok_off = '0; lx_tok_line = 24'd1; lx_tok_col = 16'd1;
    foreach (lx_prefix[i]) lx_prefix[i] = 8'h00;
  endfunction

  function automatic void lx_advance(logic [7:0] c);
    if (lx_off != '1) lx_off++;
    if (c == CH_LF) begin
      if (lx_line != '1) lx_line++;
      lx_col = 16'd1;
    end else if (lx_col != '1) begin
      lx_col++;
    end
  endfunction

  function automatic void lx_mark();
    lx_tok_off = lx_off; lx_tok_line = lx_line; lx_tok_col = lx_col;
  endfunction

  function automatic void lx_emit(logic [5:0] k);
    token_word_t t;
    t.kind = k; t.offset = lx_tok_off; t.length = lx_off - lx_tok_off;
    t.line = lx_tok_line; t.column = lx_tok_col; t.last = 1'b0;
    lx_run.push_back(t);
  endfunction

  // keyword lookup on the stored prefix
  function automatic logic [5:0] word_kind();
    logic [31:0] len;
    string       txt;
    string       kw[10];
    len = lx_off - lx_tok_off;
    kw = '{"else", "false", "fn", "for", "if", "let", "print", "return", "true", "while"};
    if (len > 6) return K_IDENT;
    txt = "";
    for (int i = 0; i < len; i++) txt = {txt, string'(lx_prefix[i])};
    foreach (kw[i]) if (kw[i] == txt) return 6'd27 + 6'(i);
    return K_IDENT;
  endfunction

  function automatic logic [5:0] one_op(logic [7:0] c);
    case (c)
      CH_MINUS: return K_MINUS;
      CH_LT:    return K_LT;
      CH_GT:    return K_GT;
      CH_EQ:    return K_ASSIGN;
      CH_BANG:  return K_NOT;
      default:  return K_BAD;
    endcase
  endfunction

  function automatic logic [5:0] two_op(logic [7:0] c, logic [7:0] n);
    if (c == CH_MINUS && n == CH_GT) return K_ARROW;
    if (c == CH_LT && n == CH_EQ) return K_LE;
    if (c == CH_GT && n == CH_EQ) return K_GE;
    if (c == CH_EQ && n == CH_EQ) return K_EQ;
    if (c == CH_BANG && n == CH_EQ) return K_NE;
    if (c == CH_AMP && n == CH_AMP) return K_AND;
    if (c == CH_BAR && n == CH_BAR) return K_OR;
    return K_EOF;
  endfunction

  function automatic void lx_begin(logic [7:0] b);
    logic [5:0] k;
    lx_mark();
    lx_advance(b);
    if (b == CH_SPACE || b == CH_TAB || b == CH_LF || b == CH_CR) return;
    if (alpha_c(b)) begin
      foreach (lx_prefix[i]) lx_prefix[i] = 8'h00;
      lx_prefix[0] = b;
      lx_phase = S_IDENT;
      return;
    end
    if (digit_c(b)) begin
      lx_phase = S_NUM;
      return;
    end
    case (b)
      CH_QUOTE: begin lx_phase = S_STR; return; end
      CH_COMMA:  k = K_COMMA;
      CH_COLON:  k = K_COLON;
      CH_LPAREN: k = K_LPAREN;
      CH_RPAREN: k = K_RPAREN;
      CH_LBRACE: k = K_LBRACE;
      CH_RBRACE: k = K_RBRACE;
      CH_PLUS:   k = K_PLUS;
      CH_STAR:   k = K_STAR;
      CH_SLASH:  k = K_SLASH;
      CH_MINUS, CH_LT, CH_GT, CH_EQ, CH_BANG, CH_AMP, CH_BAR: begin
        lx_prefix[0] = b;
        lx_phase = S_OP;
        return;
      end
      default: k = K_BAD;
    endcase
    lx_emit(k);
  endfunction

  // close a held token without consuming a byte
  function automatic void lx_flush();
    case (lx_phase)
      S_IDENT: lx_emit(word_kind());
      S_NUM, S_FRAC: lx_emit(K_NUMBER);
      S_NUM_DOT: begin
        lx_emit(K_NUMBER);
        lx_phase = S_IDLE;
        lx_begin(CH_DOT);
      end
      S_STR: lx_emit(K_OPEN);
      S_OP: lx_emit(one_op(lx_prefix[0]));
      default: ;
    endcase
    lx_phase = S_IDLE;
  endfunction

  function automatic void lx_feed(logic [7:0] b);
    logic [31:0] len;
    logic [5:0]  k;
    case (lx_phase)
      S_IDENT: if (alpha_c(b) || digit_c(b)) begin
        len = lx_off - lx_tok_off;
        if (len < 6) lx_prefix[len] = b;
        lx_advance(b);
        return;
      end
      S_NUM: begin
        if (digit_c(b)) begin lx_advance(b); return; end
        if (b == CH_DOT) begin lx_phase = S_NUM_DOT; return; end
      end
      S_NUM_DOT: if (digit_c(b)) begin
        lx_advance(CH_DOT);
        lx_advance(b);
        lx_phase = S_FRAC;
        return;
      end
      S_FRAC: if (digit_c(b)) begin lx_advance(b); return; end
      S_STR: begin
        lx_advance(b);
        if (b == CH_QUOTE) begin
          lx_emit(K_STRING);
          lx_phase = S_IDLE;
        end
        return;
      end
      S_OP: begin
        k = two_op(lx_prefix[0], b);
        if (k != K_EOF) begin
          lx_advance(b);
          lx_emit(k);
          lx_phase = S_IDLE;
          return;
        end
      end
      default: begin lx_begin(b); return; end
    endcase
    lx_flush();
    lx_begin(b);
  endfunction

  // predict the tokens of one accepted word and queue them
  function automatic void lex_word(src_word_t w);
    lx_run.delete();
    if (w.fin || w.ch == 8'h00) begin
      lx_flush();
      lx_mark();
      lx_emit(K_EOF);
    end else begin
      lx_feed(w.ch);
    end
    if (lx_run.size() > 0) lx_run[$].last = 1'b1;
    foreach (lx_run[i]) expected_tokens.push_back(lx_run[i]);
  endfunction

  task automatic report_mismatch(string what, token_word_t got, token_word_t want);
    mismatch_count++;
    $display("token %s: got k%0d o%0d l%0d ln%0d c%0d e%0b, want k%0d o%0d l%0d ln%0d c%0d e%0b",
             what, got.kind, got.offset, got.length, got.line, got.column, got.last,
             want.kind, want.offset, want.length, want.line, want.column, want.last);
  endtask

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 25);
  endfunction

  // driver: change inputs on the falling edge
  int  send_gap;
  bit  hold_for_drain;
  initial begin
    in_chan.valid = 1'b0;
    in_chan.source_byte = 8'h00;
    in_chan.end_of_input = 1'b0;
    send_gap = 0;
    in_taken = 1'b0;
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      in_chan.valid <= 1'b0;
    end else begin
      if (in_taken) send_gap = gap_len();
      if (in_chan.valid && !in_taken) begin
        // hold the word until taken
      end else if (send_gap > 0) begin
        send_gap--;
        in_chan.valid <= 1'b0;
      end else if (pending_bytes.size() > 0 && pending_bytes[0].fin === 1'bx) begin
        in_chan.valid <= 1'b0;
      end else if (hold_for_drain && expected_tokens.size() > 0) begin
        in_chan.valid <= 1'b0;
      end else if (pending_bytes.size() > 0) begin
        src_word_t w;
        hold_for_drain = 1'b0;
        w = pending_bytes.pop_front();
        in_chan.valid <= 1'b1;
        in_chan.source_byte <= w.ch;
        in_chan.end_of_input <= w.fin;
      end else begin
        in_chan.valid <= 1'b0;
      end
    end
  end

  // sink stall pattern
  int take_gap;
  initial begin
    out_chan.ready = 1'b0;
    take_gap = 0;
  end

  always @(negedge clk) begin
    if (!rst_n || take_gap > 0) begin
      out_chan.ready <= 1'b0;
      if (take_gap > 0) take_gap--;
    end else begin
      out_chan.ready <= 1'b1;
      take_gap = ($urandom_range(0, 3) == 0) ? gap_len() : 0;
    end
  end

  // monitor: compare tokens and predict from accepted bytes on the rising edge
  always @(posedge clk) begin
    token_word_t got, want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      got = '{out_chan.token_kind, out_chan.start_offset, out_chan.lexeme_len,
              out_chan.first_line, out_chan.first_col, out_chan.last_of_run};
      if (expected_tokens.size() == 0) begin
        report_mismatch("unexpected", got, '0);
      end else begin
        want = expected_tokens.pop_front();
        if (got !== want) report_mismatch("differs", got, want);
      end
    end
    in_taken = rst_n && in_chan.valid && in_chan.ready;
    if (in_taken) begin
      lex_word('{in_chan.source_byte, in_chan.end_of_input});
      sent_count++;
    end
  end

  task automatic put_text(string s);
    for (int i = 0; i < s.len(); i++) pending_bytes.push_back('{s[i], 1'b0});
  endtask

  task automatic put_byte(logic [7:0] c, logic fin);
    pending_bytes.push_back('{c, fin});
  endtask

  // snippets used to build well-formed random text
  string pieces[] = '{"let", "x", "while", "print", "return", "fn", "for", "if",
    "else", "true", "false", "foo_1", "Ab", "letter", "returns", "42", "3.14", "7.",
    "\"hi\"", "\"a\nb\"", "->", "<=", ">=", "==", "!=", "&&", "||", "-", "<", ">",
    "=", "!", "&", "|", ",", ":", "(", ")", "{", "}", "+", "*", "/", " ", "\n",
    "\t", "\r", "  "};

  initial begin
    int n;
    mismatch_count = 0;
    sent_count = 0;
    hold_for_drain = 1'b0;
    lx_clear();
    rst_n = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed: keywords, operators, numbers, strings, bad bytes, ends
    put_text("let fn if");
    put_byte(8'h00, 1'b0);
    put_text("x<=1.5 7.a&|");
    put_byte(8'hFF, 1'b0);
    put_byte(8'h80, 1'b0);
    put_text("\"open");
    put_byte(8'h41, 1'b1);
    put_text("12.");
    put_byte(8'h00, 1'b1);

    // random text: mostly snippets, some raw noise
    n = 0;
    while (n < 145) begin
      int r;
      r = $urandom_range(0, 99);
      if (r < 75) begin
        put_text(pieces[$urandom_range(0, pieces.size() - 1)]);
      end else if (r < 93) begin
        put_byte(8'($urandom_range(1, 255)), 1'b0);
      end else begin
        put_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      end
      n = pending_bytes.size();
      if (n > 120 && n < 130 && !hold_for_drain) begin
        // wait for the block to drain once in the middle
        while (pending_bytes.size() > 0) @(posedge clk);
        hold_for_drain = 1'b1;
        n = 130;
        while (pending_bytes.size() == 0 && n < 145) begin
          put_text(pieces[$urandom_range(0, pieces.size() - 1)]);
          n = 145 - 120 + pending_bytes.size();
        end
      end
    end
    put_byte(8'h00, 1'b1);

    while (pending_bytes.size() > 0 || in_chan.valid) @(posedge clk);
    while (expected_tokens.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatch_count == 0 && expected_tokens.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

[script_token_lexer.f]
sv/slx_pkg.sv
sv/slx_ifs.sv
sv/slx_front.sv
sv/slx_queue.sv
sv/slx_back.sv
sv/script_token_lexer.sv
test/script_token_lexer_test.sv
